### hdl/bpc_pkg.sv
// shared types, codes and reset values for the button press classifier
package bpc_pkg;

	localparam int unsigned HOLD_TIMER_BITS_DEF = 20;
	localparam int unsigned CFG_DATA_W = 20;
	localparam int unsigned CFG_INDEX_W = 3;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_IDLE_PERIOD = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DEB_PERIOD = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEB_THRESHOLD = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_HOLD = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SECOND_HOLD = 3'd4;

	// register reset values
	localparam logic [15:0] IDLE_PERIOD_RST = 16'd50;
	localparam logic [15:0] DEB_PERIOD_RST = 16'd5;
	localparam logic [7:0] DEB_THRESHOLD_RST = 8'd4;
	localparam logic [19:0] FIRST_HOLD_RST = 20'd3000;
	localparam logic [19:0] SECOND_HOLD_RST = 20'd3000;

	typedef enum logic [1:0] {
		EVT_NONE = 2'd0,
		EVT_SHORT = 2'd1,
		EVT_LONG = 2'd2
	} press_event_t;

	typedef enum logic [2:0] {
		LED_NONE = 3'd0,
		LED_ON = 3'd1,
		LED_OFF = 3'd2,
		LED_SLOW = 3'd3,
		LED_PAIR = 3'd4
	} led_cmd_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_DEBOUNCE = 4'b0010,
		PH_PRESSED = 4'b0100,
		PH_HELD = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [15:0] idle_sample_period;
		logic [15:0] debounce_sample_period;
		logic [7:0] debounce_threshold;
		logic [19:0] first_hold_ticks;
		logic [19:0] second_hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic debounced_pressed;
		led_cmd_t led_command;
		press_event_t press_event;
	} result_t;

endpackage

### hdl/button_press_classifier.sv
// top level: debounced button classifier with stream ports and register port
//
// Each input beat is one millisecond tick; s_axis_tdata[0] is the button level
// (1 pressed). Every input beat yields exactly one output beat carrying the
// press event, an LED command and the debounced level.
// The tick is captured in an input stage, then the phase machine, debounce
// counter and timers update and the result lands in an output register. One
// beat per cycle is sustained while the receiver keeps m_axis_tready high.
// When the receiver stalls, the output register holds its beat and the input
// stage holds one more; s_axis_tready drops only when both are full.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the
// user must write them only while no beat is in flight; the block does not enforce it.
// cfg_ready is always high. Index 0 idle sample period, 1 debounce sample period,
// 2 debounce threshold, 3 first hold ticks, 4 second hold ticks; other indexes are ignored.
// Reset (arst_n low) returns the phase to idle, clears counter and timers,
// empties both stages and loads the register defaults (50, 5, 4, 3000, 3000).
module button_press_classifier #(
	parameter int unsigned HOLD_TIMER_BITS = bpc_pkg::HOLD_TIMER_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // [0] button_pressed, rest zero
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [7:0] m_axis_tdata, // [1:0] press_event, [4:2] led_command, [5] debounced_pressed
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data
);

	bpc_pkg::cfg_t cfg_q;
	logic valid_s1;
	logic pressed_s1;
	logic out_valid_q;
	bpc_pkg::result_t out_q;
	bpc_pkg::result_t result;
	logic advance;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_sample_period <= bpc_pkg::IDLE_PERIOD_RST;
			cfg_q.debounce_sample_period <= bpc_pkg::DEB_PERIOD_RST;
			cfg_q.debounce_threshold <= bpc_pkg::DEB_THRESHOLD_RST;
			cfg_q.first_hold_ticks <= bpc_pkg::FIRST_HOLD_RST;
			cfg_q.second_hold_ticks <= bpc_pkg::SECOND_HOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bpc_pkg::REG_IDLE_PERIOD: cfg_q.idle_sample_period <= cfg_data[15:0];
				bpc_pkg::REG_DEB_PERIOD: cfg_q.debounce_sample_period <= cfg_data[15:0];
				bpc_pkg::REG_DEB_THRESHOLD: cfg_q.debounce_threshold <= cfg_data[7:0];
				bpc_pkg::REG_FIRST_HOLD: cfg_q.first_hold_ticks <= cfg_data[19:0];
				bpc_pkg::REG_SECOND_HOLD: cfg_q.second_hold_ticks <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pressed_s1 <= s_axis_tdata[0];
		end
		if (advance) begin
			out_q <= result;
		end
	end

	bpc_core #(
		.HOLD_TIMER_BITS(HOLD_TIMER_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.tick(advance),
		.pressed(pressed_s1),
		.cfg(cfg_q),
		.result(result)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {2'b00, out_q};

	// a held input beat must never be overwritten while the output is stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input stage accepted while full");

	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_axis_tvalid)
		else $error("processed tick lost before output");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:6] == 2'b00))
		else $error("output padding not zero");

endmodule

### hdl/bpc_core.sv
// phase machine, debounce counter, sample and hold timers for one tick per beat
module bpc_core #(
	parameter int unsigned HOLD_TIMER_BITS = bpc_pkg::HOLD_TIMER_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic tick,
	input logic pressed,
	input bpc_pkg::cfg_t cfg,
	output bpc_pkg::result_t result
);

	localparam int unsigned CMP_W = (HOLD_TIMER_BITS > 20) ? HOLD_TIMER_BITS : 20;
	localparam logic [HOLD_TIMER_BITS-1:0] HOLD_MAX = '1;

	bpc_pkg::phase_t phase_q, phase_d;
	logic [7:0] cnt_q, cnt_d;
	logic [15:0] sample_q, sample_d;
	logic [HOLD_TIMER_BITS-1:0] hold_q, hold_d;

	logic [15:0] elapsed;
	logic [15:0] period;
	logic [CMP_W-1:0] hold_ext;
	logic first_hit;
	logic second_hit;
	logic [7:0] cnt_dec;
	logic [7:0] cnt_capped;
	logic [7:0] cnt_sat;

	always_comb begin
		elapsed = (sample_q == 16'hFFFF) ? sample_q : sample_q + 16'd1;
		period = (phase_q == bpc_pkg::PH_IDLE) ? cfg.idle_sample_period
			: cfg.debounce_sample_period;
		cnt_dec = (cnt_q != 8'd0) ? cnt_q - 8'd1 : cnt_q;
		cnt_sat = (cnt_q != 8'hFF) ? cnt_q + 8'd1 : cnt_q;
		cnt_capped = (cnt_q < cfg.debounce_threshold && cnt_q != 8'hFF) ? cnt_q + 8'd1 : cnt_q;

		phase_d = phase_q;
		cnt_d = cnt_q;
		result.press_event = bpc_pkg::EVT_NONE;
		result.led_command = bpc_pkg::LED_NONE;

		// hold timer runs only once the press is confirmed
		if (phase_q == bpc_pkg::PH_PRESSED || phase_q == bpc_pkg::PH_HELD) begin
			hold_d = (hold_q != HOLD_MAX) ? hold_q + HOLD_TIMER_BITS'(1) : hold_q;
		end else begin
			hold_d = '0;
		end
		hold_ext = CMP_W'(hold_d);
		first_hit = hold_ext >= CMP_W'(cfg.first_hold_ticks);
		second_hit = hold_ext >= CMP_W'(cfg.second_hold_ticks);

		if (elapsed < period) begin
			sample_d = elapsed;
		end else begin
			sample_d = '0;
			case (phase_q)
				bpc_pkg::PH_IDLE: begin
					if (pressed) begin
						cnt_d = 8'd1;
						phase_d = bpc_pkg::PH_DEBOUNCE;
						result.led_command = bpc_pkg::LED_ON;
					end
				end
				bpc_pkg::PH_DEBOUNCE: begin
					if (pressed) begin
						if (cfg.debounce_threshold <= cnt_q) begin
							phase_d = bpc_pkg::PH_PRESSED;
							hold_d = '0;
							result.led_command = bpc_pkg::LED_ON;
						end
						cnt_d = cnt_sat;
					end else if (cnt_q == 8'd0) begin
						phase_d = bpc_pkg::PH_IDLE;
						result.led_command = bpc_pkg::LED_OFF;
					end else begin
						cnt_d = cnt_dec;
					end
				end
				bpc_pkg::PH_PRESSED: begin
					if (pressed) begin
						cnt_d = cnt_capped;
						if (first_hit) begin
							phase_d = bpc_pkg::PH_HELD;
							hold_d = '0;
							result.led_command = bpc_pkg::LED_SLOW;
						end
					end else begin
						cnt_d = cnt_dec;
						if (cnt_dec == 8'd0) begin
							phase_d = bpc_pkg::PH_IDLE;
							hold_d = '0;
							result.press_event = bpc_pkg::EVT_SHORT;
							result.led_command = bpc_pkg::LED_OFF;
						end
					end
				end
				default: begin
					if (pressed) begin
						cnt_d = cnt_capped;
						if (second_hit) begin
							result.led_command = bpc_pkg::LED_ON;
						end
					end else if (cnt_q == 8'd0) begin
						phase_d = bpc_pkg::PH_IDLE;
						hold_d = '0;
						result.press_event = bpc_pkg::EVT_LONG;
						result.led_command = bpc_pkg::LED_PAIR;
					end else begin
						cnt_d = cnt_dec;
					end
				end
			endcase
		end

		result.debounced_pressed = (phase_d == bpc_pkg::PH_PRESSED)
			|| (phase_d == bpc_pkg::PH_HELD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bpc_pkg::PH_IDLE;
			cnt_q <= '0;
			sample_q <= '0;
			hold_q <= '0;
		end else if (tick) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			sample_q <= sample_d;
			hold_q <= hold_d;
		end
	end

	// idle always leaves the counter and hold timer cleared
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bpc_pkg::PH_IDLE) |-> (cnt_q == 8'd0 && hold_q == '0))
		else $error("idle phase with live counter or hold timer");

	a_hold_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bpc_pkg::PH_DEBOUNCE) |-> (hold_q == '0))
		else $error("hold timer running before press confirmed");

	a_event_release: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && result.press_event != bpc_pkg::EVT_NONE) |=> (phase_q == bpc_pkg::PH_IDLE))
		else $error("press event without return to idle");

	a_long_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && result.press_event == bpc_pkg::EVT_LONG)
		|-> (result.led_command == bpc_pkg::LED_PAIR && !result.debounced_pressed))
		else $error("long press without pairing flash");

endmodule
